// ===== rtl/mts_pkg.sv =====
// shared types, constants and the control store of the march test sequencer
// no dependencies; imported by every module of the block
package mts_pkg;

  localparam int unsigned IdxW   = 21;
  localparam int unsigned CntW   = 22;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned StepW  = 4;

  localparam logic [CntW-1:0]  MaxWords  = 22'd2097152;
  localparam logic [DataW-1:0] HashMulA  = 32'h9E37_79B9;
  localparam logic [DataW-1:0] HashMulB  = 32'h7FEB_352D;
  localparam logic [DataW-1:0] HashMask  = 32'hA5A5_5A5A;
  localparam logic [DataW-1:0] AllOnes   = 32'hFFFF_FFFF;

  // march phases
  localparam logic [PhaseW-1:0] PhWrZero  = 3'd0;
  localparam logic [PhaseW-1:0] PhOnes    = 3'd1;
  localparam logic [PhaseW-1:0] PhPattern = 3'd2;
  localparam logic [PhaseW-1:0] PhInverse = 3'd3;
  localparam logic [PhaseW-1:0] PhClear   = 3'd4;
  localparam logic [PhaseW-1:0] PhVerify  = 3'd5;

  // configuration register indexes
  localparam logic RegWordCount = 1'b0;
  localparam logic RegBaseAddr  = 1'b1;

  typedef enum logic [1:0] {
    StatAccess = 2'd0,
    StatPass   = 2'd1,
    StatFail   = 2'd2,
    StatIdle   = 2'd3
  } mts_status_e;

  typedef enum logic [3:0] {
    OpNone    = 4'd0,
    OpStart   = 4'd1,
    OpAdvance = 4'd2,
    OpHash1   = 4'd3,
    OpHash2   = 4'd4,
    OpIssue   = 4'd5,
    OpPass    = 4'd6,
    OpFail    = 4'd7,
    OpIdle    = 4'd8
  } mts_op_e;

  typedef enum logic [2:0] {
    CondNext     = 3'd0,
    CondAlways   = 3'd1,
    CondNoInput  = 3'd2,
    CondStart    = 3'd3,
    CondIdle     = 3'd4,
    CondMismatch = 3'd5,
    CondDone     = 3'd6,
    CondZero     = 3'd7
  } mts_cond_e;

  typedef struct packed {
    mts_op_e          op;
    mts_cond_e        cond;
    logic [StepW-1:0] target;
  } mts_uword_t;

  typedef struct packed {
    logic    take;
    mts_op_e op;
  } mts_ctrl_t;

  typedef struct packed {
    logic func_start;
    logic not_running;
    logic mismatch;
    logic run_done;
    logic zero_words;
    logic out_full;
  } mts_flags_t;

  // program step addresses
  localparam logic [StepW-1:0] StWait     = 4'd0;
  localparam logic [StepW-1:0] StDispatch = 4'd1;
  localparam logic [StepW-1:0] StChkRun   = 4'd2;
  localparam logic [StepW-1:0] StChkData  = 4'd3;
  localparam logic [StepW-1:0] StAdvance  = 4'd4;
  localparam logic [StepW-1:0] StChkDone  = 4'd5;
  localparam logic [StepW-1:0] StHash1    = 4'd6;
  localparam logic [StepW-1:0] StHash2    = 4'd7;
  localparam logic [StepW-1:0] StIssue    = 4'd8;
  localparam logic [StepW-1:0] StStart    = 4'd9;
  localparam logic [StepW-1:0] StChkZero  = 4'd10;
  localparam logic [StepW-1:0] StGoHash   = 4'd11;
  localparam logic [StepW-1:0] StPass     = 4'd12;
  localparam logic [StepW-1:0] StFail     = 4'd13;
  localparam logic [StepW-1:0] StIdle     = 4'd14;

  function automatic mts_uword_t mts_ucode(input logic [StepW-1:0] step);
    mts_uword_t uw;
    case (step)
      StWait:     uw = '{OpNone,    CondNoInput,  StWait};
      StDispatch: uw = '{OpNone,    CondStart,    StStart};
      StChkRun:   uw = '{OpNone,    CondIdle,     StIdle};
      StChkData:  uw = '{OpNone,    CondMismatch, StFail};
      StAdvance:  uw = '{OpAdvance, CondNext,     StWait};
      StChkDone:  uw = '{OpNone,    CondDone,     StPass};
      StHash1:    uw = '{OpHash1,   CondNext,     StWait};
      StHash2:    uw = '{OpHash2,   CondNext,     StWait};
      StIssue:    uw = '{OpIssue,   CondAlways,   StWait};
      StStart:    uw = '{OpStart,   CondNext,     StWait};
      StChkZero:  uw = '{OpNone,    CondZero,     StPass};
      StGoHash:   uw = '{OpNone,    CondAlways,   StHash1};
      StPass:     uw = '{OpPass,    CondAlways,   StWait};
      StFail:     uw = '{OpFail,    CondAlways,   StWait};
      StIdle:     uw = '{OpIdle,    CondAlways,   StWait};
      default:    uw = '{OpNone,    CondAlways,   StWait};
    endcase
    return uw;
  endfunction

endpackage

// ===== rtl/march_memory_test_sequencer.sv =====
// top level of the march memory test sequencer
// depends on mts_pkg, mts_ctrl, mts_datapath (which holds mts_hash)
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in       | in_valid_i/in_ready_o  | func_i, read_data_i
//  out      | out_valid_o/out_ready_i| status_o, word_index_o, read/write_enable_o,
//           |                        | write_data_o, phase_o, expected/actual_value_o
//  cfg      | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// one transaction at a time; after an accept the program walks the dispatch checks
// (start, idle, mismatch), then the march advance, the done check, the two hash stages
// and the step that issues an access; a start walks the zero-count check, the two hash
// stages and the issue step; failing, finishing and idle steps go to their emit step
// reset clears the step counter, march state, configuration registers and result valid
// a full result register holds the program at its emit step until taken
module march_memory_test_sequencer import mts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [DataW-1:0]   read_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [IdxW-1:0]    word_index_o,
  output logic               read_enable_o,
  output logic               write_enable_o,
  output logic [DataW-1:0]   write_data_o,
  output logic [PhaseW-1:0]  phase_o,
  output logic [DataW-1:0]   expected_value_o,
  output logic [DataW-1:0]   actual_value_o
);

  mts_ctrl_t  ctrl;
  mts_flags_t flags;

  mts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .flags_i    (flags),
    .ctrl_o     (ctrl)
  );

  mts_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .flags_o          (flags),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .func_i           (func_i),
    .read_data_i      (read_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .word_index_o     (word_index_o),
    .read_enable_o    (read_enable_o),
    .write_enable_o   (write_enable_o),
    .write_data_o     (write_data_o),
    .phase_o          (phase_o),
    .expected_value_o (expected_value_o),
    .actual_value_o   (actual_value_o)
  );

endmodule

// ===== rtl/mts_ctrl.sv =====
// microprogram sequencer: step counter, control store fetch, conditional jumps
// depends on mts_pkg
module mts_ctrl import mts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  mts_flags_t flags_i,
  output mts_ctrl_t  ctrl_o
);

  logic [StepW-1:0] upc_q, upc_d;
  mts_uword_t       uw;
  logic             take;
  logic             emit;
  logic             stall;
  logic             jump;

  assign uw         = mts_ucode(upc_q);
  assign in_ready_o = (upc_q == StWait);
  assign take       = in_ready_o & in_valid_i;

  always_comb begin
    emit  = uw.op inside {OpIssue, OpPass, OpFail, OpIdle};
    stall = emit & flags_i.out_full;
  end

  always_comb begin
    case (uw.cond)
      CondNext:     jump = 1'b0;
      CondAlways:   jump = 1'b1;
      CondNoInput:  jump = !take;
      CondStart:    jump = flags_i.func_start;
      CondIdle:     jump = flags_i.not_running;
      CondMismatch: jump = flags_i.mismatch;
      CondDone:     jump = flags_i.run_done;
      CondZero:     jump = flags_i.zero_words;
      default:      jump = 1'b1;
    endcase
  end

  always_comb begin
    if (stall) begin
      upc_d = upc_q;
    end else if (jump) begin
      upc_d = uw.target;
    end else begin
      upc_d = upc_q + StepW'(1);
    end
  end

  assign ctrl_o.take = take;
  assign ctrl_o.op   = stall ? OpNone : uw.op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= StWait;
    end else begin
      upc_q <= upc_d;
    end
  end

  a_take_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> upc_q == StDispatch)
    else $error("accepted transaction did not reach dispatch");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(upc_q))
    else $error("step counter moved while result register full");

endmodule

// ===== rtl/mts_hash.sv =====
// two-stage address/index pattern hash, one multiply per stage
// depends on mts_pkg
module mts_hash import mts_pkg::*; (
  input  logic             clk_i,
  input  logic             stage1_en_i,
  input  logic             stage2_en_i,
  input  logic [IdxW-1:0]  index_i,
  input  logic [DataW-1:0] base_i,
  output logic [DataW-1:0] pattern_o
);

  logic [DataW-1:0] idx_ext;
  logic [DataW-1:0] addr;
  logic [DataW-1:0] mul_a;
  logic [DataW-1:0] fold;
  logic [DataW-1:0] mul_b;
  logic [DataW-1:0] mix_q;
  logic [DataW-1:0] prod_q;

  assign idx_ext = {{(DataW-IdxW){1'b0}}, index_i};
  assign addr    = base_i + {idx_ext[DataW-3:0], 2'b00};
  assign mul_a   = idx_ext * HashMulA;
  assign fold    = mix_q ^ (mix_q >> 16);
  assign mul_b   = fold * HashMulB;

  always_ff @(posedge clk_i) begin
    if (stage1_en_i) begin
      mix_q <= addr ^ mul_a;
    end
    if (stage2_en_i) begin
      prod_q <= mul_b;
    end
  end

  assign pattern_o = prod_q ^ (prod_q >> 15) ^ HashMask;

endmodule

// ===== rtl/mts_datapath.sv =====
// march state, address stepping, checking and the result register
// depends on mts_pkg and mts_hash
module mts_datapath import mts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mts_ctrl_t          ctrl_i,
  output mts_flags_t         flags_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  input  logic               func_i,
  input  logic [DataW-1:0]   read_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [IdxW-1:0]    word_index_o,
  output logic               read_enable_o,
  output logic               write_enable_o,
  output logic [DataW-1:0]   write_data_o,
  output logic [PhaseW-1:0]  phase_o,
  output logic [DataW-1:0]   expected_value_o,
  output logic [DataW-1:0]   actual_value_o
);

  logic [CntW-1:0]   word_count_q;
  logic [DataW-1:0]  base_addr_q;
  logic [CntW-1:0]   run_words_q, run_words_d;
  logic [DataW-1:0]  run_base_q;
  logic              running_q;
  logic              check_pending_q;
  logic [DataW-1:0]  pending_expected_q;
  logic [PhaseW-1:0] cur_phase_q;
  logic [IdxW-1:0]   cur_index_q;
  logic [PhaseW-1:0] nxt_phase_q, adv_phase;
  logic [IdxW-1:0]   nxt_index_q, adv_index;
  logic              done_q, adv_done;
  logic              func_q;
  logic [DataW-1:0]  rdata_q;
  logic              out_valid_q;
  logic              load;

  logic [DataW-1:0]  pattern;
  logic [IdxW-1:0]   last_index;
  logic [PhaseW-1:0] phase_inc;
  logic              iss_rd, iss_we;
  logic [DataW-1:0]  iss_wd, iss_ex;

  logic [1:0]        res_status;
  logic [IdxW-1:0]   res_index;
  logic              res_rd, res_we;
  logic [DataW-1:0]  res_wd;
  logic [PhaseW-1:0] res_phase;
  logic [DataW-1:0]  res_ex, res_ac;

  mts_hash u_hash (
    .clk_i       (clk_i),
    .stage1_en_i (ctrl_i.op == OpHash1),
    .stage2_en_i (ctrl_i.op == OpHash2),
    .index_i     (nxt_index_q),
    .base_i      (run_base_q),
    .pattern_o   (pattern)
  );

  assign run_words_d = (word_count_q > MaxWords) ? MaxWords : word_count_q;
  assign last_index  = IdxW'(run_words_q - CntW'(1));
  assign phase_inc   = cur_phase_q + PhaseW'(1);

  // next word and phase of the march
  always_comb begin
    adv_phase = cur_phase_q;
    adv_index = cur_index_q;
    adv_done  = 1'b0;
    if (cur_phase_q == PhInverse || cur_phase_q == PhClear) begin
      if (cur_index_q != '0) begin
        adv_index = cur_index_q - IdxW'(1);
      end else begin
        adv_phase = phase_inc;
        adv_index = (phase_inc == PhClear) ? last_index : '0;
      end
    end else begin
      if (({1'b0, cur_index_q} + CntW'(1)) < run_words_q) begin
        adv_index = cur_index_q + IdxW'(1);
      end else if (cur_phase_q >= PhVerify) begin
        adv_done = 1'b1;
      end else begin
        adv_phase = phase_inc;
        adv_index = (phase_inc == PhInverse) ? last_index : '0;
      end
    end
  end

  // access fields of the issued phase
  always_comb begin
    iss_rd = 1'b1;
    iss_we = 1'b1;
    iss_wd = '0;
    iss_ex = '0;
    case (nxt_phase_q)
      PhWrZero:  iss_rd = 1'b0;
      PhOnes:    iss_wd = AllOnes;
      PhPattern: begin
        iss_ex = AllOnes;
        iss_wd = pattern;
      end
      PhInverse: begin
        iss_ex = pattern;
        iss_wd = ~pattern;
      end
      PhClear:   iss_ex = ~pattern;
      default:   iss_we = 1'b0;
    endcase
  end

  assign load = (ctrl_i.op == OpIssue) || (ctrl_i.op == OpPass)
             || (ctrl_i.op == OpFail)  || (ctrl_i.op == OpIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q       <= '0;
      base_addr_q        <= '0;
      run_words_q        <= '0;
      run_base_q         <= '0;
      running_q          <= 1'b0;
      check_pending_q    <= 1'b0;
      pending_expected_q <= '0;
      cur_phase_q        <= '0;
      cur_index_q        <= '0;
      nxt_phase_q        <= '0;
      nxt_index_q        <= '0;
      done_q             <= 1'b0;
      out_valid_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegWordCount: word_count_q <= cfg_wdata_i[CntW-1:0];
          RegBaseAddr:  base_addr_q  <= cfg_wdata_i;
          default:      base_addr_q  <= cfg_wdata_i;
        endcase
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (ctrl_i.op)
        OpStart: begin
          run_words_q     <= run_words_d;
          run_base_q      <= base_addr_q;
          running_q       <= (run_words_d != '0);
          check_pending_q <= 1'b0;
          cur_phase_q     <= PhWrZero;
          cur_index_q     <= '0;
          nxt_phase_q     <= PhWrZero;
          nxt_index_q     <= '0;
          done_q          <= 1'b0;
        end
        OpAdvance: begin
          nxt_phase_q <= adv_phase;
          nxt_index_q <= adv_index;
          done_q      <= adv_done;
        end
        OpIssue: begin
          cur_phase_q        <= nxt_phase_q;
          cur_index_q        <= nxt_index_q;
          check_pending_q    <= iss_rd;
          pending_expected_q <= iss_ex;
        end
        OpPass, OpFail: begin
          running_q       <= 1'b0;
          check_pending_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // result payload for the emitting op
  always_comb begin
    res_status = StatIdle;
    res_index  = '0;
    res_rd     = 1'b0;
    res_we     = 1'b0;
    res_wd     = '0;
    res_phase  = '0;
    res_ex     = '0;
    res_ac     = '0;
    case (ctrl_i.op)
      OpIssue: begin
        res_status = StatAccess;
        res_index  = nxt_index_q;
        res_rd     = iss_rd;
        res_we     = iss_we;
        res_wd     = iss_wd;
        res_phase  = nxt_phase_q;
        res_ex     = iss_ex;
      end
      OpFail: begin
        res_status = StatFail;
        res_index  = cur_index_q;
        res_phase  = cur_phase_q;
        res_ex     = pending_expected_q;
        res_ac     = rdata_q;
      end
      OpPass:  res_status = StatPass;
      default: res_status = StatIdle;
    endcase
  end

  // transaction payload and result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      func_q  <= func_i;
      rdata_q <= read_data_i;
    end
    if (load) begin
      status_o         <= res_status;
      word_index_o     <= res_index;
      read_enable_o    <= res_rd;
      write_enable_o   <= res_we;
      write_data_o     <= res_wd;
      phase_o          <= res_phase;
      expected_value_o <= res_ex;
      actual_value_o   <= res_ac;
    end
  end

  assign out_valid_o = out_valid_q;

  assign flags_o.func_start  = !func_q;
  assign flags_o.not_running = !running_q;
  assign flags_o.mismatch    = check_pending_q && (rdata_q != pending_expected_q);
  assign flags_o.run_done    = done_q;
  assign flags_o.zero_words  = (run_words_q == '0);
  assign flags_o.out_full    = out_valid_q && !out_ready_i;

  a_pending_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    check_pending_q |-> cur_phase_q != PhWrZero)
    else $error("read check pending after a write-only phase");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> {1'b0, cur_index_q} < run_words_q)
    else $error("word index beyond the tested range");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_phase_q <= PhVerify && nxt_phase_q <= PhVerify)
    else $error("march phase out of range");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("result not presented after load");

endmodule
